[design/ibd_pkg.sv]
// ----------------------------------------------------------------------------
// IMU batch deframer package
// Shared types and constants for the sync/length framed byte deframer.
// ----------------------------------------------------------------------------
package ibd_pkg;

  localparam int unsigned MAX_SAMPLES = 7;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned SAMPLE_W    = 5;
  localparam int unsigned LEN_W       = 8;

  localparam logic [7:0]  MAX_SAMPLES_B = 8'(MAX_SAMPLES);
  localparam logic [7:0]  SYNC_RESET    = 8'hAA;

  typedef enum logic [1:0] {
    EV_WORD   = 2'd0,
    EV_EMPTY  = 2'd1,
    EV_REJECT = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    KIND_MAG   = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_GYRO  = 2'd2
  } kind_e;

  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    event_e           event_res;
    logic [31:0]      word;
    kind_e            sensor_kind;
    logic [CNT_W-1:0] sample_index;
    logic [1:0]       axis;
    logic             last_word;
  } result_t;

endpackage

[design/imu_batch_deframer_core.sv]
// ----------------------------------------------------------------------------
// IMU batch deframer core
// Byte stream deframer: sync hunt, three count header, tagged payload words.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the input channel (in_valid_i, in_stall_o, data_byte_i), one
// beat per byte. Results leave on the output channel (out_valid_o,
// out_stall_i) as one beat carrying event code, word and tag fields.
// A byte produces at most one result beat. The byte is held in the input
// register until the frame logic consumes it; the frame logic is combinational
// and the output register loads the result when the byte is consumed, so the
// result is presented from the output register.
// Throughput is one byte per cycle while the receiver does not stall the
// output; the frame logic updates its state for each consumed byte.
// The user must write the sync byte (0xAA after reset) on the cfg channel
// (cfg_valid_i, cfg_ready_o, cfg_data_i) while the block is idle; unenforced.
// Reset puts the block in sync hunt and empties both registers.
// When the receiver stalls, the output beat holds; one more byte can be
// taken into the input register before in_stall_o rises.
// ----------------------------------------------------------------------------
module imu_batch_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_res_o,
  output logic [31:0] word_o,
  output logic [1:0]  sensor_kind_o,
  output logic [2:0]  sample_index_o,
  output logic [1:0]  axis_o,
  output logic        last_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import ibd_pkg::*;

  logic       adv;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  logic [7:0] sync_q;

  assign adv         = !out_valid_o || !out_stall_i;
  assign fire        = s1_valid && adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else if (cfg_valid_i) begin
      sync_q <= cfg_data_i;
    end
  end

  ibd_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .adv_i       (adv),
    .in_stall_o  (in_stall_o),
    .valid_o     (s1_valid),
    .byte_o      (s1_byte)
  );

  ibd_frame_ctl u_frame_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_i       (s1_byte),
    .sync_value_i (sync_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ibd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_valid_i (fire && res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign event_res_o    = out_res.event_res;
  assign word_o         = out_res.word;
  assign sensor_kind_o  = out_res.sensor_kind;
  assign sample_index_o = out_res.sample_index;
  assign axis_o         = out_res.axis;
  assign last_word_o    = out_res.last_word;

`ifndef SYNTH
  a_event_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != EV_WORD) |->
      (word_o == '0) && (sensor_kind_o == '0) && (sample_index_o == '0) &&
      (axis_o == '0) && !last_word_o)
    else $error("event beat carries nonzero payload fields");

  a_word_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_WORD) |->
      (axis_o != 2'd3) && (sensor_kind_o != 2'd3))
    else $error("payload beat has an illegal tag");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output path is free");

  a_no_result_without_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !s1_valid |=> !out_valid_o)
    else $error("result beat without an accepted byte");
`endif
endmodule

[design/ibd_in_reg.sv]
// ----------------------------------------------------------------------------
// Input register
// Captures one byte beat from the input channel and holds it until the
// frame logic consumes it.
// ----------------------------------------------------------------------------
module ibd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       adv_i,
  output logic       in_stall_o,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  assign load       = !valid_q || adv_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
endmodule

[design/ibd_frame_ctl.sv]
// ----------------------------------------------------------------------------
// Frame control
// Sync hunt, header count check and payload word assembly with tagging.
// Produces at most one result per consumed byte.
// ----------------------------------------------------------------------------
module ibd_frame_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic [7:0]        sync_value_i,
  output logic              res_valid_o,
  output ibd_pkg::result_t  res_o
);
  import ibd_pkg::*;

  localparam logic [1:0] PH_SYNC    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]          phase_q, phase_d;
  logic [1:0]          hdr_pos_q, hdr_pos_d;
  logic [CNT_W-1:0]    mag_q, mag_d;
  logic [CNT_W-1:0]    acc_q, acc_d;
  logic                too_q, too_d;
  logic [LEN_W-1:0]    pos_q, pos_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [23:0]         part_q, part_d;
  logic [SAMPLE_W-1:0] gs_q, gs_d;
  logic [1:0]          axis_q, axis_d;

  logic [SAMPLE_W-1:0] sum;
  logic [LEN_W-1:0]    len_new;
  logic [SAMPLE_W-1:0] mag_w, acc_w, rel_acc, rel_gyro;
  logic [LEN_W:0]      pos_inc;
  logic                last;

  assign mag_w    = SAMPLE_W'(mag_q);
  assign acc_w    = SAMPLE_W'(acc_q);
  assign sum      = mag_w + acc_w + SAMPLE_W'(byte_i[CNT_W-1:0]);
  assign len_new  = {sum, 3'b000} + {1'b0, sum, 2'b00};
  assign rel_acc  = gs_q - mag_w;
  assign rel_gyro = gs_q - mag_w - acc_w;
  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign last     = pos_inc >= {1'b0, len_q};

  always_comb begin
    phase_d     = phase_q;
    hdr_pos_d   = hdr_pos_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    too_d       = too_q;
    pos_d       = pos_q;
    len_d       = len_q;
    part_d      = part_q;
    gs_d        = gs_q;
    axis_d      = axis_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire_i) begin
      case (phase_q)
        PH_HEADER: begin
          too_d = too_q || (byte_i > MAX_SAMPLES_B);
          if (hdr_pos_q == 2'd0) begin
            mag_d     = byte_i[CNT_W-1:0];
            hdr_pos_d = 2'd1;
          end else if (hdr_pos_q == 2'd1) begin
            acc_d     = byte_i[CNT_W-1:0];
            hdr_pos_d = 2'd2;
          end else begin
            hdr_pos_d = 2'd0;
            phase_d   = PH_SYNC;
            if (too_d) begin
              too_d           = 1'b0;
              res_valid_o     = 1'b1;
              res_o.event_res = EV_REJECT;
            end else begin
              len_d = len_new;
              if (len_new == '0) begin
                res_valid_o     = 1'b1;
                res_o.event_res = EV_EMPTY;
              end else begin
                pos_d   = '0;
                part_d  = '0;
                gs_d    = '0;
                axis_d  = '0;
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          pos_d = pos_inc[LEN_W-1:0];
          case (pos_q[1:0])
            2'd0: part_d[7:0]   = byte_i;
            2'd1: part_d[15:8]  = byte_i;
            2'd2: part_d[23:16] = byte_i;
            default: begin
              res_valid_o     = 1'b1;
              res_o.event_res = EV_WORD;
              res_o.word      = {byte_i, part_q};
              res_o.axis      = axis_q;
              res_o.last_word = last;
              if (gs_q < mag_w) begin
                res_o.sensor_kind  = KIND_MAG;
                res_o.sample_index = gs_q[CNT_W-1:0];
              end else if (rel_acc < acc_w) begin
                res_o.sensor_kind  = KIND_ACCEL;
                res_o.sample_index = rel_acc[CNT_W-1:0];
              end else begin
                res_o.sensor_kind  = KIND_GYRO;
                res_o.sample_index = rel_gyro[CNT_W-1:0];
              end
              part_d = '0;
              if (axis_q == AXIS_Z) begin
                axis_d = '0;
                gs_d   = gs_q + 1'b1;
              end else begin
                axis_d = axis_q + 1'b1;
              end
              if (last) begin
                phase_d = PH_SYNC;
                pos_d   = '0;
              end
            end
          endcase
        end
        default: begin
          if (byte_i == sync_value_i) begin
            phase_d   = PH_HEADER;
            hdr_pos_d = 2'd0;
            too_d     = 1'b0;
          end else begin
            phase_d = PH_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC;
      hdr_pos_q <= '0;
      mag_q     <= '0;
      acc_q     <= '0;
      too_q     <= 1'b0;
      pos_q     <= '0;
      len_q     <= '0;
      part_q    <= '0;
      gs_q      <= '0;
      axis_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      mag_q     <= mag_d;
      acc_q     <= acc_d;
      too_q     <= too_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      part_q    <= part_d;
      gs_q      <= gs_d;
      axis_q    <= axis_d;
    end
  end
endmodule

[design/ibd_out_reg.sv]
// ----------------------------------------------------------------------------
// Output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ibd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             res_valid_i,
  input  ibd_pkg::result_t res_i,
  output logic             out_valid_o,
  output ibd_pkg::result_t res_o
);
  import ibd_pkg::*;

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
endmodule
